// File: rtl/core/tjct_pkg.sv
// Package with the shared types and constants of the tick interval tracker.
`timescale 1ns / 1ps

package tjct_pkg;

  localparam int unsigned IVL_W = 16;
  localparam int unsigned TICK_W = 64;
  localparam int unsigned TGT_W = IVL_W + 2;

  localparam logic [IVL_W-1:0] IVL_MAX = 16'hffff;
  localparam logic [TGT_W-1:0] TARGET_BIAS = 18'd4;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             en;
    logic [IVL_W-1:0] data;
  } ring_wr_t;

endpackage

// File: rtl/core/tjct_ring.sv
// Interval ring: synchronous memory with write pointer and fill count.
`timescale 1ns / 1ps

module tjct_ring #(
  parameter int unsigned RING_DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tjct_pkg::ring_wr_t     wr,
  input  logic                   rd_en,
  input  logic [IDX_W-1:0]       rd_idx,
  output logic [tjct_pkg::IVL_W-1:0] rd_data,
  output logic                   rd_ok
);
  import tjct_pkg::*;

  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

  logic [IVL_W-1:0] mem [RING_DEPTH];
  logic [IDX_W-1:0] wpos_r, wpos_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IVL_W-1:0] rd_data_r;
  logic             rd_ok_r;

  // Entries are written in order from zero, so an index below the fill
  // count has been written; a read of any other index returns zero.
  always_comb begin
    wpos_nxt = wpos_r;
    fill_nxt = fill_r;
    if (wr.en) begin
      wpos_nxt = (wpos_r == LAST_IDX) ? '0 : wpos_r + 1'b1;
      fill_nxt = (fill_r == FULL_CNT) ? fill_r : fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      fill_r <= '0;
    end else begin
      wpos_r <= wpos_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wpos_r] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
      rd_ok_r   <= (CNT_W'(rd_idx) < fill_r);
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;
  assign rd_ok   = rd_ok_r;

endmodule

// File: rtl/core/tick_jitter_catchup_tracker.sv
// Top level of the tick interval tracker with catch-up derivation.
// Record item: the result is loaded from the REC state once the output is free; no new item
//   is taken until then. Update item: the result follows the SCAN, DRAIN and DONE states;
//   the maximum walk reads one ring entry a cycle through the single read port.
// A stalled result holds the next item in its final state. Synchronous active-low reset
//   clears previous tick, pointer, fill count and catch-up; no ring clearing pass.
`timescale 1ns / 1ps

module tick_jitter_catchup_tracker #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [tjct_pkg::TICK_W-1:0] in_tick_value,
  input  logic [tjct_pkg::IVL_W-1:0]  in_current_interval,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_interval_recorded,
  output logic [tjct_pkg::IVL_W-1:0]  out_catchup_amount
);
  import tjct_pkg::*;

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  state_t state_r, state_nxt;

  // Latched item.
  logic              op_r;
  logic [TICK_W-1:0] tick_r;
  logic [IVL_W-1:0]  cur_r;

  // Architectural state outside the ring.
  logic [TICK_W-1:0] prev_tick_r;
  logic [IVL_W-1:0]  catchup_r;

  // Scan control.
  logic [IDX_W-1:0]  scan_idx_r;
  logic              rd_vld_r;
  logic [IVL_W-1:0]  max_r;

  // Result register.
  logic              out_valid_r;
  logic              out_rec_r;
  logic [IVL_W-1:0]  out_catchup_r;

  // Ring interface.
  ring_wr_t          ring_wr;
  logic              rd_en;
  logic [IVL_W-1:0]  rd_data;
  logic              rd_ok;

  // Datapath terms.
  logic              in_xfer;
  logic              out_free;
  logic              rec_fire;
  logic              done_fire;
  logic              tick_same;
  logic              prev_known;
  logic [TICK_W-1:0] gap;
  logic [IVL_W-1:0]  gap_sat;
  logic [TGT_W-1:0]  target_raw;
  logic [IVL_W-1:0]  target;
  logic [IVL_W-1:0]  catchup_new;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_operation == OP_UPDATE) ? ST_SCAN : ST_REC;
        end
      end
      ST_REC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    rec_fire  = 1'b0;
    done_fire = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall  = 1'b0;
      ST_REC:   rec_fire  = out_free;
      ST_SCAN:  rd_en     = 1'b1;
      ST_DRAIN: rd_en     = 1'b0;
      ST_DONE:  done_fire = out_free;
      default:  in_stall  = 1'b1;
    endcase
  end

  // Record path: interval from the old previous tick, clamped to 16 bits.
  assign tick_same  = (tick_r == prev_tick_r);
  assign prev_known = (prev_tick_r != '0);
  assign gap        = (tick_r > prev_tick_r) ? (tick_r - prev_tick_r) : '0;
  assign gap_sat    = (gap[TICK_W-1:IVL_W] != '0) ? IVL_MAX : gap[IVL_W-1:0];

  assign ring_wr.en   = rec_fire && !tick_same && prev_known;
  assign ring_wr.data = gap_sat;

  // Update path: target = max + max/16 + bias, saturated.
  assign target_raw  = {2'b00, max_r} + {6'b000000, max_r[IVL_W-1:4]} + TARGET_BIAS;
  assign target      = (target_raw > TGT_W'(IVL_MAX)) ? IVL_MAX : target_raw[IVL_W-1:0];
  assign catchup_new = (cur_r > target) ? (cur_r - target) : '0;

  tjct_ring #(
    .RING_DEPTH(RING_DEPTH),
    .IDX_W     (IDX_W)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (ring_wr),
    .rd_en  (rd_en),
    .rd_idx (scan_idx_r),
    .rd_data(rd_data),
    .rd_ok  (rd_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_tick_r <= '0;
      catchup_r   <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;

      // Advance the read address through the ring.
      if (in_xfer) begin
        scan_idx_r <= '0;
      end else if (rd_en) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end

      // Load a finished result, else drop it once the far side takes it.
      if (rec_fire || done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (rec_fire && !tick_same) begin
        prev_tick_r <= tick_r;
      end

      // With no known tick the catch-up holds its value.
      if (done_fire && prev_known) begin
        catchup_r <= catchup_new;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_operation;
      tick_r <= in_tick_value;
      cur_r  <= in_current_interval;
      max_r  <= '0;
    end else if (rd_vld_r && rd_ok && (rd_data > max_r)) begin
      max_r <= rd_data;
    end

    if (rec_fire) begin
      out_rec_r     <= ring_wr.en;
      out_catchup_r <= catchup_r;
    end else if (done_fire) begin
      out_rec_r     <= (op_r == OP_RECORD);
      out_catchup_r <= prev_known ? catchup_new : catchup_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_interval_recorded = out_rec_r;
  assign out_catchup_amount    = out_catchup_r;

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the tick interval tracker: random and directed transfers.
`timescale 1ns / 1ps

module testbench;

  import tjct_pkg::*;

  localparam int unsigned RING_DEPTH = 16;
  // An update walks the whole ring; allow that plus some slack before the verdict.
  localparam int unsigned SETTLE_CYCLES = RING_DEPTH + 12;
  localparam int unsigned RANDOM_ITEMS = 1700;

  typedef struct {
    logic              op;
    logic [TICK_W-1:0] tick;
    logic [IVL_W-1:0]  cur;
    bit                drain_first;
  } tick_item_t;

  typedef struct packed {
    logic             recorded;
    logic [IVL_W-1:0] catchup;
  } catchup_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_operation = OP_RECORD;
  logic [TICK_W-1:0] in_tick_value = '0;
  logic [IVL_W-1:0]  in_current_interval = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_interval_recorded;
  logic [IVL_W-1:0]  out_catchup_amount;

  tick_item_t      tick_items_q[$];
  catchup_result_t catchup_expect_q[$];
  int unsigned     total_items = 0;
  int unsigned     n_accepted = 0;
  int unsigned     fail_count = 0;

  // Predictor state: mirrors the tracker's previous tick, interval ring and catch-up.
  logic [TICK_W-1:0] pred_prev_tick = '0;
  logic [IVL_W-1:0]  ivl_ring[RING_DEPTH];
  int unsigned       ring_pos = 0;
  logic [IVL_W-1:0]  catchup_now = '0;

  tick_jitter_catchup_tracker #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_tick_value        (in_tick_value),
    .in_current_interval  (in_current_interval),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_interval_recorded(out_interval_recorded),
    .out_catchup_amount   (out_catchup_amount)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // Advance the predicted tracker state by one accepted item and return its result.
  function automatic catchup_result_t advance_tracker(logic op, logic [TICK_W-1:0] tick,
                                                      logic [IVL_W-1:0] cur);
    logic [TICK_W-1:0] gap;
    logic [IVL_W-1:0]  top;
    logic [TGT_W-1:0]  target;
    catchup_result_t   res;
    res.recorded = 1'b0;
    if (op == OP_RECORD) begin
      // A repeated tick changes nothing at all.
      if (tick != pred_prev_tick) begin
        // With no previous tick known, only remember this one.
        if (pred_prev_tick != '0) begin
          // A tick going backwards counts as a zero interval.
          gap = (pred_prev_tick > tick) ? '0 : tick - pred_prev_tick;
          ivl_ring[ring_pos] = (gap > TICK_W'(IVL_MAX)) ? IVL_MAX : gap[IVL_W-1:0];
          ring_pos = (ring_pos + 1) % RING_DEPTH;
          res.recorded = 1'b1;
        end
        pred_prev_tick = tick;
      end
    end else if (pred_prev_tick != '0) begin
      // Update with no tick known leaves the catch-up untouched.
      top = '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        if (ivl_ring[i] > top) top = ivl_ring[i];
      end
      target = TGT_W'(top) + TGT_W'(top >> 4) + TARGET_BIAS;
      if (target > TGT_W'(IVL_MAX)) target = TGT_W'(IVL_MAX);
      catchup_now = (TGT_W'(cur) > target) ? IVL_W'(TGT_W'(cur) - target) : '0;
    end
    res.catchup = catchup_now;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic queue_item(logic op, logic [TICK_W-1:0] tick, logic [IVL_W-1:0] cur,
                            bit drain_first = 1'b0);
    tick_item_t it;
    it.op = op;
    it.tick = tick;
    it.cur = cur;
    it.drain_first = drain_first;
    tick_items_q.push_back(it);
  endtask

  // Idle rates by phase: the first third stalls the receiver hard, the second
  // stalls the sender hard, the last third runs both sides flat out.
  function automatic bit sender_idles();
    if (n_accepted < total_items / 3) return $urandom_range(0, 99) < 24;
    if (n_accepted < 2 * total_items / 3) return $urandom_range(0, 99) < 79;
    return 1'b0;
  endfunction

  function automatic bit receiver_idles();
    if (n_accepted < total_items / 3) return $urandom_range(0, 99) < 79;
    if (n_accepted < 2 * total_items / 3) return $urandom_range(0, 99) < 24;
    return 1'b0;
  endfunction

  // Driver: on every transfer predict the result, then present the next item
  // or drop valid. Payload only changes when a new item goes out.
  always @(posedge clk) begin
    bit              took;
    bit              hold_off;
    tick_item_t      it;
    catchup_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        res = advance_tracker(in_operation, in_tick_value, in_current_interval);
        catchup_expect_q.push_back(res);
        n_accepted++;
      end
      if (!in_valid || took) begin
        // Hold a flagged item back until every outstanding result has come.
        hold_off = tick_items_q.size() > 0 && tick_items_q[0].drain_first &&
                   catchup_expect_q.size() > 0;
        if (tick_items_q.size() > 0 && !hold_off && !sender_idles()) begin
          it = tick_items_q.pop_front();
          in_valid <= 1'b1;
          in_operation <= it.op;
          in_tick_value <= it.tick;
          in_current_interval <= it.cur;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation, then
  // pick the stall for the next cycle.
  always @(posedge clk) begin
    catchup_result_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (catchup_expect_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          exp_res = catchup_expect_q.pop_front();
          if (out_interval_recorded !== exp_res.recorded)
            report_mismatch($sformatf("interval_recorded %b, expected %b",
                                      out_interval_recorded, exp_res.recorded));
          if (out_catchup_amount !== exp_res.catchup)
            report_mismatch($sformatf("catchup_amount %0d, expected %0d",
                                      out_catchup_amount, exp_res.catchup));
        end
      end
      out_stall <= receiver_idles();
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [TICK_W-1:0] gen_tick;
    logic [TICK_W-1:0] gap;
    logic [IVL_W-1:0]  cur;
    int unsigned       run_len;
    int unsigned       pick;
    bit                drain;

    for (int i = 0; i < RING_DEPTH; i++) ivl_ring[i] = '0;

    // Directed: update before any tick, zero tick as first tick, first tick,
    // repeat, saturating interval, target overflow, backwards tick, zero after
    // a known tick, all-ones tick, then a short normal interval.
    queue_item(OP_UPDATE, '0, IVL_MAX);
    queue_item(OP_RECORD, '0, '0);
    queue_item(OP_RECORD, 64'd1, '0);
    queue_item(OP_RECORD, 64'd1, IVL_MAX);
    queue_item(OP_RECORD, 64'd1 + 64'd200000, '0);
    queue_item(OP_UPDATE, '1, IVL_MAX);
    queue_item(OP_UPDATE, '0, '0);
    queue_item(OP_RECORD, 64'd50, '0);
    queue_item(OP_RECORD, '0, '0);
    queue_item(OP_UPDATE, '0, 16'd1234);
    queue_item(OP_RECORD, '1, '0);
    queue_item(OP_RECORD, '1, '0);
    queue_item(OP_RECORD, 64'h5555_5555_5555_5555, 16'h5555);
    queue_item(OP_RECORD, '0, '0);
    queue_item(OP_RECORD, 64'd100, '0);
    queue_item(OP_RECORD, 64'd100 + 64'd65535, '0);
    queue_item(OP_RECORD, 64'd100 + 64'd65535 + 64'd65536, '0);
    queue_item(OP_UPDATE, '0, IVL_MAX);
    queue_item(OP_RECORD, 64'd100 + 64'd65535 + 64'd65546, 16'haaaa);
    queue_item(OP_UPDATE, 64'haaaa_aaaa_aaaa_aaaa, 16'd20);

    // Random: mostly monotonic tick runs with interleaved updates, some noise.
    gen_tick = 64'd100 + 64'd65535 + 64'd65546;
    drain = 1'b1;
    while (tick_items_q.size() < 20 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) gen_tick = TICK_W'($urandom_range(1, 1000));
        else if (pick < 4) gen_tick = {$urandom, $urandom};
        else if (pick == 4) gen_tick = '1 - TICK_W'($urandom_range(0, 5000));
        run_len = $urandom_range(2, 24);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 99) < 30) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) cur = IVL_W'($urandom_range(0, 300));
            else if (pick < 80) cur = IVL_W'($urandom_range(0, 6000));
            else cur = IVL_W'($urandom);
            queue_item(OP_UPDATE, {$urandom, $urandom}, cur, drain);
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) gap = TICK_W'($urandom_range(1, 200));
            else if (pick < 85) gap = TICK_W'($urandom_range(200, 5000));
            else if (pick < 93) gap = TICK_W'($urandom_range(60000, 70000));
            else if (pick < 97) gap = {$urandom, $urandom};
            else gap = '0;
            gen_tick = gen_tick + gap;
            queue_item(OP_RECORD, gen_tick, IVL_W'($urandom), drain);
          end
          drain = (tick_items_q.size() % 250) == 0;
        end
      end else begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: gen_tick = '0;
          1: gen_tick = '1;
          2: gen_tick = gen_tick - 64'd1;
          3: gen_tick = TICK_W'($urandom_range(1, 10));
          4: gen_tick = gen_tick;
          default: gen_tick = {$urandom, $urandom};
        endcase
        queue_item($urandom_range(0, 1) ? OP_UPDATE : OP_RECORD, gen_tick,
                   IVL_W'($urandom));
      end
    end
    total_items = tick_items_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go out and every result to come back, then settle.
    while (tick_items_q.size() > 0 || in_valid || catchup_expect_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
